FILE: hdl/lpqs_pkg.sv
// ----------------------------------------------------------------------------
// lpqs_pkg
// Shared types, constants and the dimming curve for the quarter-scan
// LED panel refresh block.
// ----------------------------------------------------------------------------
package lpqs_pkg;

  localparam int CHAIN_MAX_DEF       = 4;
  localparam int BYTES_PER_PANEL_ROW = 4;
  localparam int ROWS_MAX            = 16;
  localparam int ROW_BYTES_W         = 5;
  localparam int HEIGHT_W            = 5;
  localparam int USED_W              = 9;
  localparam int QUEUE_DEPTH         = 2;
  localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_FILL  = 2'd1,
    OP_SWAP  = 2'd2,
    OP_SCAN  = 2'd3
  } lpqs_op_t;

  typedef enum logic [1:0] {
    REG_CHAIN  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BRIGHT = 2'd2,
    REG_EN_LOW = 2'd3
  } lpqs_reg_t;

  typedef struct packed {
    lpqs_op_t   op;
    logic       on;
    logic       copy;
    logic       ok;
    logic [3:0] col;
    logic [3:0] row;
    logic [7:0] mask;
  } lpqs_cmd_t;

  typedef struct packed {
    logic [ROW_BYTES_W-1:0] row_bytes;
    logic [HEIGHT_W-1:0]    height;
    logic [USED_W-1:0]      used;
    logic [7:0]             pwm;
  } lpqs_cfg_t;

  localparam logic [7:0] CURVE [256] = '{
    8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,
    8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
    8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd6,
    8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd7,
    8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,
    8'd9,   8'd9,   8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
    8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,  8'd13,  8'd13,
    8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,  8'd15,  8'd15,  8'd16,  8'd16,
    8'd16,  8'd16,  8'd17,  8'd17,  8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,
    8'd19,  8'd20,  8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
    8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,  8'd27,  8'd27,
    8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,  8'd31,  8'd32,  8'd32,  8'd33,
    8'd33,  8'd34,  8'd35,  8'd35,  8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,
    8'd40,  8'd40,  8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
    8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,
    8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,
    8'd68,  8'd69,  8'd70,  8'd71,  8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,
    8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
    8'd96,  8'd98,  8'd99,  8'd101, 8'd103, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112,
    8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125, 8'd127, 8'd129, 8'd132, 8'd134,
    8'd136, 8'd139, 8'd141, 8'd144, 8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159,
    8'd162, 8'd165, 8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
    8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218, 8'd222, 8'd226,
    8'd230, 8'd234, 8'd238, 8'd242, 8'd247, 8'd252
  };

endpackage

FILE: hdl/lpqs_front.sv
// ----------------------------------------------------------------------------
// lpqs_front
// Accepts command items, range-checks pixel writes and builds the bit
// mask, then pushes a decoded command into the queue.
// ----------------------------------------------------------------------------
module lpqs_front (
  input  logic               clk,
  input  logic               rst,
  input  lpqs_pkg::lpqs_cfg_t cfg,
  input  logic               clearing,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // pixel_x[6:0], pixel_y[10:7], pixel_on[11], copy[12]
  input  logic [1:0]         s_tuser,   // cmd[1:0]
  input  logic               q_ready,
  output logic               q_push,
  output lpqs_pkg::lpqs_cmd_t q_data
);
  import lpqs_pkg::*;

  logic [6:0] px;
  logic [3:0] py;
  logic       x_ok;
  logic       y_ok;
  logic       busy;

  assign px = s_tdata[6:0];
  assign py = s_tdata[10:7];

  assign x_ok = {1'b0, px} < {cfg.row_bytes, 3'b000};
  assign y_ok = {1'b0, py} < cfg.height;

  // hold off after reset so the clear pass is seen before accepting
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign s_tready = q_ready && !clearing && !busy;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_data.op   = lpqs_op_t'(s_tuser);
    q_data.on   = s_tdata[11];
    q_data.copy = s_tdata[12];
    q_data.ok   = x_ok && y_ok;
    q_data.col  = px[6:3];
    q_data.row  = py;
    q_data.mask = 8'h80 >> px[2:0];
  end

endmodule

FILE: hdl/lpqs_queue.sv
// ----------------------------------------------------------------------------
// lpqs_queue
// Short command queue between the decode front and the execution engine.
// ----------------------------------------------------------------------------
module lpqs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lpqs_pkg::lpqs_cmd_t push_data,
  output logic               ready,
  output logic               valid,
  output lpqs_pkg::lpqs_cmd_t data,
  input  logic               pop
);
  import lpqs_pkg::*;

  lpqs_cmd_t              entry [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign ready   = count != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign data    = entry[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/lpqs_engine.sv
// ----------------------------------------------------------------------------
// lpqs_engine
// Holds both frame stores and runs the commands: clear pass, pixel
// read-modify-write, fill, swap with optional copy, and the scan of one row.
// ----------------------------------------------------------------------------
module lpqs_engine (
  input  logic               clk,
  input  logic               rst,
  input  lpqs_pkg::lpqs_cfg_t cfg,
  input  logic               q_valid,
  input  lpqs_pkg::lpqs_cmd_t q_data,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_row,
  output logic [31:0]        out_word,
  output logic               out_last,
  output logic [7:0]         out_pwm
);
  import lpqs_pkg::*;

  localparam int STORE_DEPTH = CHAIN_MAX_DEF * BYTES_PER_PANEL_ROW * ROWS_MAX;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CW          = (ADDR_W > USED_W) ? ADDR_W : USED_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_FILL,
    ST_COPY,
    ST_COPY_END,
    ST_SCAN_RD,
    ST_SCAN_FIN,
    ST_SCAN_OUT
  } state_t;

  state_t                 state;
  logic [7:0]             mem_a [STORE_DEPTH];
  logic [7:0]             mem_b [STORE_DEPTH];
  logic [7:0]             rd_a;
  logic [7:0]             rd_b;
  logic [ADDR_W-1:0]      cnt;
  logic [ADDR_W-1:0]      pix_addr;
  logic [ADDR_W-1:0]      cp_addr;
  logic                   front_is_b;
  logic [1:0]             scan_row;
  logic [ROW_BYTES_W-1:0] byte_i;
  logic [1:0]             kk;
  logic                   pend;
  logic                   pend_ok;
  logic [31:0]            word;
  logic                   cur_on;
  logic [7:0]             cur_mask;

  logic [7:0]             front_rd;
  logic [7:0]             back_rd;
  logic [7:0]             scan_byte;
  logic [31:0]            word_full;
  logic [ADDR_W-1:0]      q_addr;
  logic [ADDR_W-1:0]      scan_addr;
  logic [3:0]             scan_line;
  logic                   scan_ok;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic [7:0]             wr_data;
  logic                   we_back;
  logic                   we_both;
  logic                   we_a;
  logic                   we_b;
  logic                   cnt_last;
  logic                   clear_last;
  logic                   word_last;
  logic                   out_free;

  assign front_rd  = front_is_b ? rd_b : rd_a;
  assign back_rd   = front_is_b ? rd_a : rd_b;
  assign scan_byte = pend_ok ? ~front_rd : 8'hFF;
  assign word_full = {word[23:0], scan_byte};

  assign q_addr = ADDR_W'(USED_W'(q_data.row) * USED_W'(cfg.row_bytes)
                          + USED_W'(q_data.col));
  assign scan_line = {kk, scan_row};
  assign scan_ok   = {1'b0, scan_line} < cfg.height;
  assign scan_addr = ADDR_W'(USED_W'(scan_line) * USED_W'(cfg.row_bytes)
                             + USED_W'(byte_i));

  assign cnt_last   = CW'(cnt) == CW'(cfg.used - USED_W'(1));
  assign clear_last = cnt == ADDR_W'(STORE_DEPTH - 1);
  assign word_last  = byte_i == cfg.row_bytes - ROW_BYTES_W'(1);
  assign out_free   = !out_valid || out_ready;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign clearing = state == ST_CLEAR;

  always_comb begin
    case (state)
      ST_COPY:    rd_addr = cnt;
      ST_SCAN_RD: rd_addr = scan_addr;
      default:    rd_addr = q_addr;
    endcase
  end

  always_comb begin
    we_back = 1'b0;
    we_both = 1'b0;
    wr_addr = cnt;
    wr_data = 8'h00;
    case (state)
      ST_CLEAR: begin
        we_both = 1'b1;
      end
      ST_PIX_WR: begin
        we_back = 1'b1;
        wr_addr = pix_addr;
        wr_data = cur_on ? (back_rd | cur_mask) : (back_rd & ~cur_mask);
      end
      ST_FILL: begin
        we_back = 1'b1;
        wr_data = {8{cur_on}};
      end
      ST_COPY, ST_COPY_END: begin
        we_back = pend;
        wr_addr = cp_addr;
        wr_data = front_rd;
      end
      default: begin
        we_back = 1'b0;
      end
    endcase
  end

  assign we_a = we_both || (we_back && front_is_b);
  assign we_b = we_both || (we_back && !front_is_b);

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b <= mem_b[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      front_is_b <= 1'b0;
      scan_row   <= 2'd0;
      out_valid  <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_SCAN_FIN && state != ST_SCAN_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clear_last) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur_on <= q_data.on;
            cnt    <= '0;
            pend   <= 1'b0;
            case (q_data.op)
              OP_PIXEL: begin
                pix_addr <= q_addr;
                cur_mask <= q_data.mask;
                if (q_data.ok) begin
                  state <= ST_PIX_WR;
                end
              end
              OP_FILL: begin
                if (cfg.used != '0) begin
                  state <= ST_FILL;
                end
              end
              OP_SWAP: begin
                front_is_b <= !front_is_b;
                if (q_data.copy && cfg.used != '0) begin
                  state <= ST_COPY;
                end
              end
              OP_SCAN: begin
                kk     <= 2'd3;
                byte_i <= '0;
                state  <= ST_SCAN_RD;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_PIX_WR: begin
          state <= ST_IDLE;
        end
        ST_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= ST_IDLE;
          end
        end
        ST_COPY: begin
          pend    <= 1'b1;
          cp_addr <= cnt;
          cnt     <= cnt + 1'b1;
          if (cnt_last) begin
            state <= ST_COPY_END;
          end
        end
        ST_COPY_END: begin
          pend  <= 1'b0;
          state <= ST_IDLE;
        end
        ST_SCAN_RD: begin
          if (pend) begin
            word <= word_full;
          end
          pend    <= 1'b1;
          pend_ok <= scan_ok;
          kk      <= kk - 2'd1;
          if (kk == 2'd0) begin
            state <= ST_SCAN_FIN;
          end
        end
        ST_SCAN_FIN, ST_SCAN_OUT: begin
          pend <= 1'b0;
          if (state == ST_SCAN_FIN) begin
            word <= word_full;
          end
          if (out_free) begin
            out_valid <= 1'b1;
            out_row   <= scan_row;
            out_word  <= (state == ST_SCAN_FIN) ? word_full : word;
            out_last  <= word_last;
            out_pwm   <= cfg.pwm;
            if (word_last) begin
              scan_row <= scan_row + 2'd1;
              state    <= ST_IDLE;
            end else begin
              byte_i <= byte_i + 1'b1;
              kk     <= 2'd3;
              state  <= ST_SCAN_RD;
            end
          end else begin
            state <= ST_SCAN_OUT;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_both_only_clear: assert property (@(posedge clk) disable iff (rst)
    (we_a && we_b) |-> clearing)
    else $error("both stores written outside the clear pass");

  a_swap_on_pop: assert property (@(posedge clk) disable iff (rst)
    !q_pop |=> front_is_b == $past(front_is_b))
    else $error("front store changed without a command");

  a_row_on_word: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN_FIN && state != ST_SCAN_OUT) |=> scan_row == $past(scan_row))
    else $error("scan row advanced outside a word handoff");

  a_wait_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_OUT) |-> out_valid)
    else $error("word held back while the output register is empty");

endmodule

FILE: hdl/led_panel_quarter_scan_refresh.sv
// ----------------------------------------------------------------------------
// led_panel_quarter_scan_refresh
// Double-buffered 1-bit framebuffer and 1/4-scan refresh sequencer for
// chained 32x16 LED panels.
//
//   channel  dir  handshake         payload
//   s_*      in   tvalid/tready     tuser cmd; tdata pixel_x, pixel_y, on, copy
//   m_*      out  tvalid/tready     tdata row_select, shift_word, pwm; tlast latch
//   apb      in   psel/penable      panel_chain, panel_height, brightness, en_low
//
// scan tick: each word is four reads on the front store's single read port plus
//   a handoff; a tick sends chain*4 words, one per byte of the row
// fill and copy: one byte a cycle over chain*4*height bytes; pixel: read then write
// after reset a clear pass writes both stores, CHAIN_MAX_DEF*64 bytes, no item taken
// a stalled output holds a scan; the queue, until full, keeps taking items meanwhile
// ----------------------------------------------------------------------------
module led_panel_quarter_scan_refresh (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // pixel_x[6:0], pixel_y[10:7], pixel_on[11], copy[12]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // row_select[1:0], shift_word[33:2], pwm_compare[41:34]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpqs_pkg::*;

  logic [2:0]  panel_chain;
  logic [4:0]  panel_height;
  logic [7:0]  brightness;
  logic        enable_active_low;
  logic [2:0]  chain_used;
  lpqs_cfg_t   cfg;
  lpqs_reg_t   reg_sel;
  logic        cfg_wr;
  logic        clearing;
  logic        push;
  lpqs_cmd_t   push_data;
  logic        q_ready;
  logic        q_valid;
  lpqs_cmd_t   q_data;
  logic        q_pop;
  logic [1:0]  out_row;
  logic [31:0] out_word;
  logic [7:0]  out_pwm;

  assign pready  = 1'b1;
  assign reg_sel = lpqs_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_chain       <= 3'd1;
      panel_height      <= 5'd16;
      brightness        <= 8'd128;
      enable_active_low <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_CHAIN:  panel_chain       <= pwdata[2:0];
        REG_HEIGHT: panel_height      <= pwdata[4:0];
        REG_BRIGHT: brightness        <= pwdata[7:0];
        REG_EN_LOW: enable_active_low <= pwdata[0];
        default:    panel_chain       <= panel_chain;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CHAIN:  prdata = {29'd0, panel_chain};
      REG_HEIGHT: prdata = {27'd0, panel_height};
      REG_BRIGHT: prdata = {24'd0, brightness};
      REG_EN_LOW: prdata = {31'd0, enable_active_low};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (panel_chain == 3'd0) begin
      chain_used = 3'd1;
    end else if (32'(panel_chain) > CHAIN_MAX_DEF) begin
      chain_used = 3'(CHAIN_MAX_DEF);
    end else begin
      chain_used = panel_chain;
    end
    cfg.row_bytes = ROW_BYTES_W'(chain_used * BYTES_PER_PANEL_ROW);
    cfg.height    = (panel_height > HEIGHT_W'(ROWS_MAX)) ? HEIGHT_W'(ROWS_MAX)
                                                         : panel_height;
    cfg.used      = USED_W'(USED_W'(cfg.row_bytes) * USED_W'(cfg.height));
    cfg.pwm       = CURVE[brightness] ^ {8{enable_active_low}};
  end

  lpqs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_ready  (q_ready),
    .q_push   (push),
    .q_data   (push_data)
  );

  lpqs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .ready     (q_ready),
    .valid     (q_valid),
    .data      (q_data),
    .pop       (q_pop)
  );

  lpqs_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_word  (out_word),
    .out_last  (m_tlast),
    .out_pwm   (out_pwm)
  );

  assign m_tdata = {6'd0, out_pwm, out_word, out_row};

endmodule
